[hw/rtl/ctsc_pkg.sv]
package ctsc_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         kind;
    logic signed [31:0] value;
    logic [15:0]        ident_length;
    logic [23:0]        line_number;
    logic [2:0]         error_code;
    logic               last_of_item;
  } out_item_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_DEC, M_ZERO, M_OCT, M_HEX, M_SLASH, M_LINECMT,
    M_BLOCK, M_STAR, M_CH0, M_CHESC, M_CHCLOSE, M_STR, M_STRESC, M_OP
  } mode_t;

  localparam logic [5:0] K_END    = 6'd0;
  localparam logic [5:0] K_IDENT  = 6'd1;
  localparam logic [5:0] K_INT    = 6'd2;
  localparam logic [5:0] K_CHAR   = 6'd3;
  localparam logic [5:0] K_SCHAR  = 6'd4;
  localparam logic [5:0] K_SEND   = 6'd5;
  localparam logic [5:0] K_DIV    = 6'd6;
  localparam logic [5:0] K_ASSIGN = 6'd7;
  localparam logic [5:0] K_EQ     = 6'd8;
  localparam logic [5:0] K_PLUS   = 6'd9;
  localparam logic [5:0] K_INC    = 6'd10;
  localparam logic [5:0] K_MINUS  = 6'd11;
  localparam logic [5:0] K_DEC    = 6'd12;
  localparam logic [5:0] K_NOT    = 6'd13;
  localparam logic [5:0] K_NE     = 6'd14;
  localparam logic [5:0] K_LT     = 6'd15;
  localparam logic [5:0] K_LE     = 6'd16;
  localparam logic [5:0] K_SHL    = 6'd17;
  localparam logic [5:0] K_GT     = 6'd18;
  localparam logic [5:0] K_GE     = 6'd19;
  localparam logic [5:0] K_SHR    = 6'd20;
  localparam logic [5:0] K_OR     = 6'd21;
  localparam logic [5:0] K_LOR    = 6'd22;
  localparam logic [5:0] K_AND    = 6'd23;
  localparam logic [5:0] K_LAND   = 6'd24;
  localparam logic [5:0] K_XOR    = 6'd25;
  localparam logic [5:0] K_MOD    = 6'd26;
  localparam logic [5:0] K_MUL    = 6'd27;
  localparam logic [5:0] K_QUEST  = 6'd28;
  localparam logic [5:0] K_COMMA  = 6'd29;
  localparam logic [5:0] K_COLON  = 6'd30;
  localparam logic [5:0] K_SEMI   = 6'd31;
  localparam logic [5:0] K_LPAREN = 6'd32;
  localparam logic [5:0] K_RPAREN = 6'd33;
  localparam logic [5:0] K_LBRACK = 6'd34;
  localparam logic [5:0] K_RBRACK = 6'd35;
  localparam logic [5:0] K_LBRACE = 6'd36;
  localparam logic [5:0] K_RBRACE = 6'd37;
  localparam logic [5:0] K_ERR    = 6'd38;

  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_EMPTY_HEX  = 3'd1;
  localparam logic [2:0] E_CHAR_END   = 3'd2;
  localparam logic [2:0] E_CHESC_END  = 3'd3;
  localparam logic [2:0] E_CHAR_OPEN  = 3'd4;
  localparam logic [2:0] E_STRESC_END = 3'd5;
  localparam logic [2:0] E_STR_OPEN   = 3'd6;

  localparam logic [31:0] HashMul = 32'd147;
  localparam logic [23:0] LineMax = 24'hFFFFFF;
  localparam logic [15:0] LenMax  = 16'hFFFF;

  function automatic logic [5:0] op_single(input logic [7:0] f);
    case (f)
      "=": op_single = K_ASSIGN;
      "+": op_single = K_PLUS;
      "-": op_single = K_MINUS;
      "!": op_single = K_NOT;
      "<": op_single = K_LT;
      ">": op_single = K_GT;
      "|": op_single = K_OR;
      default: op_single = K_AND;
    endcase
  endfunction

  function automatic logic [5:0] op_double(input logic [7:0] f, input logic [7:0] c);
    op_double = K_END;
    case (f)
      "=": if (c == "=") op_double = K_EQ;
      "+": if (c == "+") op_double = K_INC;
      "-": if (c == "-") op_double = K_DEC;
      "!": if (c == "=") op_double = K_NE;
      "<": begin
        if (c == "=") op_double = K_LE;
        else if (c == "<") op_double = K_SHL;
      end
      ">": begin
        if (c == "=") op_double = K_GE;
        else if (c == ">") op_double = K_SHR;
      end
      "|": if (c == "|") op_double = K_LOR;
      default: if (c == "&") op_double = K_LAND;
    endcase
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      "^": single_kind = K_XOR;
      "%": single_kind = K_MOD;
      "*": single_kind = K_MUL;
      "?": single_kind = K_QUEST;
      ",": single_kind = K_COMMA;
      ":": single_kind = K_COLON;
      ";": single_kind = K_SEMI;
      "(": single_kind = K_LPAREN;
      ")": single_kind = K_RPAREN;
      "[": single_kind = K_LBRACK;
      "]": single_kind = K_RBRACK;
      "{": single_kind = K_LBRACE;
      "}": single_kind = K_RBRACE;
      default: single_kind = K_END;
    endcase
  endfunction

endpackage

[hw/rtl/c_subset_token_scanner.sv]
// A token is written to the result queue when the byte that completes it is accepted.
// Throughput: one byte per cycle unless stalled; a byte giving two tokens queues both.
// Tokens pass through a four-entry result queue; input stalls when it holds three or more.
// Reset (rst_n low, synchronous) empties the queue and returns the scanner to idle
// between tokens with line count one.
module c_subset_token_scanner
  import ctsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  mode_t       mode_r, mode_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [15:0] len_r, len_nxt;
  logic [23:0] line_r, line_nxt;
  logic        hex_r, hex_nxt;
  logic        halt_r, halt_nxt;

  out_item_t   q_mem [4];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  count_r;

  logic [7:0]  c;
  logic        accept, pop;
  logic        is_alpha, is_digit, is_oct, is_nl;
  mode_t       st_mode;
  logic [5:0]  st_kind;
  logic        do_start;
  logic        a_v, b_v;
  logic [5:0]  a_k, b_k;
  logic [31:0] a_val, b_val;
  logic [15:0] a_len;
  logic [2:0]  a_err;
  logic [5:0]  dk;
  out_item_t   ra, rb;

  assign c        = in_data.ch;
  assign in_stall = count_r > 3'd2;
  assign accept   = in_valid && !in_stall;
  assign out_valid = count_r != 3'd0;
  assign pop      = out_valid && !out_stall;
  assign out_data = q_mem[rd_ptr_r];

  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = c >= "0" && c <= "9";
  assign is_oct   = c >= "0" && c <= "7";
  assign is_nl    = c == 8'd10;
  assign dk       = op_double(accum_r[7:0], c);

  always_comb begin
    st_kind = K_END;
    if (is_alpha || c == "_") st_mode = M_IDENT;
    else if (c == "0") st_mode = M_ZERO;
    else if (is_digit) st_mode = M_DEC;
    else if (c == "#") st_mode = M_LINECMT;
    else if (c == "/") st_mode = M_SLASH;
    else if (c == "'") st_mode = M_CH0;
    else if (c == "\"") st_mode = M_STR;
    else if (c == "=" || c == "+" || c == "-" || c == "!" || c == "<" ||
             c == ">" || c == "|" || c == "&") st_mode = M_OP;
    else begin
      st_mode = M_IDLE;
      st_kind = single_kind(c);
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    hash_nxt  = hash_r;
    len_nxt   = len_r;
    line_nxt  = line_r;
    hex_nxt   = hex_r;
    halt_nxt  = halt_r;
    a_v = 1'b0; a_k = K_END; a_val = '0; a_len = '0; a_err = E_NONE;
    b_v = 1'b0; b_k = K_END; b_val = '0;
    do_start = 1'b0;
    if (in_data.end_of_source) begin
      if (!halt_r) begin
        case (mode_r)
          M_IDENT: begin a_v = 1'b1; a_k = K_IDENT; a_val = hash_r; a_len = len_r; end
          M_DEC, M_ZERO, M_OCT: begin a_v = 1'b1; a_k = K_INT; a_val = accum_r; end
          M_HEX: begin
            a_v = 1'b1;
            if (hex_r) begin a_k = K_INT; a_val = accum_r; end
            else begin a_k = K_ERR; a_err = E_EMPTY_HEX; end
          end
          M_SLASH:   begin a_v = 1'b1; a_k = K_DIV; end
          M_OP:      begin a_v = 1'b1; a_k = op_single(accum_r[7:0]); end
          M_CH0:     begin a_v = 1'b1; a_k = K_ERR; a_err = E_CHAR_END; end
          M_CHESC:   begin a_v = 1'b1; a_k = K_ERR; a_err = E_CHESC_END; end
          M_CHCLOSE: begin a_v = 1'b1; a_k = K_ERR; a_err = E_CHAR_OPEN; end
          M_STR:     begin a_v = 1'b1; a_k = K_ERR; a_err = E_STR_OPEN; end
          M_STRESC:  begin a_v = 1'b1; a_k = K_ERR; a_err = E_STRESC_END; end
          default: ;
        endcase
      end
      b_v = 1'b1;
      b_k = K_END;
      mode_nxt = M_IDLE; accum_nxt = '0; hash_nxt = '0; len_nxt = '0;
      line_nxt = 24'd1; hex_nxt = 1'b0; halt_nxt = 1'b0;
    end else if (!halt_r) begin
      case (mode_r)
        M_IDENT: begin
          if (is_alpha || is_digit || c == "_") begin
            hash_nxt = hash_r * HashMul + {24'd0, c};
            if (len_r < LenMax) len_nxt = len_r + 16'd1;
          end else begin
            a_v = 1'b1; a_k = K_IDENT; a_val = hash_r; a_len = len_r; do_start = 1'b1;
          end
        end
        M_DEC: begin
          if (is_digit) accum_nxt = (accum_r << 3) + (accum_r << 1) + {28'd0, c[3:0]};
          else begin a_v = 1'b1; a_k = K_INT; a_val = accum_r; do_start = 1'b1; end
        end
        M_ZERO: begin
          if (c == "x" || c == "X") begin mode_nxt = M_HEX; hex_nxt = 1'b0; end
          else if (is_oct) begin accum_nxt = {29'd0, c[2:0]}; mode_nxt = M_OCT; end
          else begin a_v = 1'b1; a_k = K_INT; a_val = accum_r; do_start = 1'b1; end
        end
        M_OCT: begin
          if (is_oct) accum_nxt = {accum_r[28:0], c[2:0]};
          else begin a_v = 1'b1; a_k = K_INT; a_val = accum_r; do_start = 1'b1; end
        end
        M_HEX: begin
          if (is_digit || is_alpha) begin
            hex_nxt = 1'b1;
            accum_nxt = {accum_r[27:0], 4'd0} + {28'd0, c[3:0]}
                        + ((c >= "A") ? 32'd9 : 32'd0);
          end else if (!hex_r) begin
            a_v = 1'b1; a_k = K_ERR; a_err = E_EMPTY_HEX;
            halt_nxt = 1'b1; mode_nxt = M_IDLE;
          end else begin
            a_v = 1'b1; a_k = K_INT; a_val = accum_r; do_start = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") mode_nxt = M_LINECMT;
          else if (c == "*") mode_nxt = M_BLOCK;
          else begin a_v = 1'b1; a_k = K_DIV; do_start = 1'b1; end
        end
        M_LINECMT: if (is_nl) mode_nxt = M_IDLE;
        M_BLOCK:   if (c == "*") mode_nxt = M_STAR;
        M_STAR: begin
          if (c == "/") mode_nxt = M_IDLE;
          else if (c != "*") mode_nxt = M_BLOCK;
        end
        M_CH0: begin
          if (c == "\\") mode_nxt = M_CHESC;
          else begin accum_nxt = {24'd0, c}; mode_nxt = M_CHCLOSE; end
        end
        M_CHESC: begin
          if (c == "n") accum_nxt = 32'd10;
          else if (c == "0") accum_nxt = 32'd0;
          else accum_nxt = {24'd0, c};
          mode_nxt = M_CHCLOSE;
        end
        M_CHCLOSE: begin
          a_v = 1'b1;
          if (c == "'") begin a_k = K_CHAR; a_val = accum_r; mode_nxt = M_IDLE; end
          else begin
            a_k = K_ERR; a_err = E_CHAR_OPEN; halt_nxt = 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_STR: begin
          if (c == "\"") begin a_v = 1'b1; a_k = K_SEND; mode_nxt = M_IDLE; end
          else if (c == "\\") mode_nxt = M_STRESC;
          else begin a_v = 1'b1; a_k = K_SCHAR; a_val = {24'd0, c}; end
        end
        M_STRESC: begin
          a_v = 1'b1; a_k = K_SCHAR;
          if (c == "n") a_val = 32'd10;
          else if (c == "t") a_val = 32'd9;
          else a_val = {24'd0, c};
          mode_nxt = M_STR;
        end
        M_OP: begin
          a_v = 1'b1;
          if (dk != K_END) begin a_k = dk; mode_nxt = M_IDLE; end
          else begin a_k = op_single(accum_r[7:0]); do_start = 1'b1; end
        end
        default: do_start = 1'b1;
      endcase
      if (do_start) begin
        mode_nxt = st_mode;
        if (st_mode == M_IDENT) begin hash_nxt = {24'd0, c}; len_nxt = 16'd1; end
        if (st_mode == M_DEC || st_mode == M_ZERO) accum_nxt = {28'd0, c[3:0]};
        if (st_mode == M_OP) accum_nxt = {24'd0, c};
        if (st_kind != K_END) begin b_v = 1'b1; b_k = st_kind; end
      end
      if (is_nl && line_r < LineMax) line_nxt = line_r + 24'd1;
    end
  end

  always_comb begin
    ra.kind = a_k; ra.value = a_val; ra.ident_length = a_len;
    ra.line_number = line_r; ra.error_code = a_err; ra.last_of_item = !b_v;
    rb.kind = b_k; rb.value = b_val; rb.ident_length = '0;
    rb.line_number = line_r; rb.error_code = E_NONE; rb.last_of_item = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; accum_r <= '0; hash_r <= '0; len_r <= '0;
      line_r <= 24'd1; hex_r <= 1'b0; halt_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt; accum_r <= accum_nxt; hash_r <= hash_nxt; len_r <= len_nxt;
      line_r <= line_nxt; hex_r <= hex_nxt; halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (a_v) begin
        q_mem[wr_ptr_r] <= ra;
        if (b_v) q_mem[wr_ptr_r + 2'd1] <= rb;
      end else if (b_v) begin
        q_mem[wr_ptr_r] <= rb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0; rd_ptr_r <= '0; count_r <= '0;
    end else begin
      if (accept) wr_ptr_r <= wr_ptr_r + {1'b0, a_v} + {1'b0, b_v};
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_r + (accept ? ({2'd0, a_v} + {2'd0, b_v}) : 3'd0)
                 - {2'd0, pop};
    end
  end

endmodule

[hw/rtl/ctsc_checker.sv]
module ctsc_checker
  import ctsc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("Result queue not empty after reset.");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.kind == K_ERR) == (out_data.error_code != E_NONE)))
    else $error("Error code does not match token kind.");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == K_END |-> out_data.last_of_item)
    else $error("End token is not the last of its transaction.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

endmodule

bind c_subset_token_scanner ctsc_checker u_ctsc_checker (.*);
